// ===== src/cfus_pkg.sv =====
// cfus_pkg: shared types, codes and defaults for the control-flow unwind stack
// no dependencies; imported by the interfaces, the top level and the sequencer
`default_nettype none

package cfus_pkg;

  localparam int DEF_STACK_DEPTH = 64;
  localparam int DEF_HANDLE_BITS = 32;

  localparam int CODE_W   = 3;
  localparam int FIELD_HW = 32;
  localparam int DEPTH_W  = 7;

  typedef enum logic [CODE_W-1:0] {
    REQ_PUSH        = 3'd0,
    REQ_UNWIND_CALL = 3'd1,
    REQ_FIND_LOOP   = 3'd2,
    REQ_UNWIND_LOOP = 3'd3,
    REQ_PEEK        = 3'd4,
    REQ_POP         = 3'd5
  } req_kind_t;

  typedef enum logic [CODE_W-1:0] {
    NK_IF       = 3'd0,
    NK_WHILE    = 3'd1,
    NK_DO_WHILE = 3'd2,
    NK_FOR      = 3'd3,
    NK_CALL     = 3'd4,
    NK_BLOCK    = 3'd5
  } node_kind_t;

  typedef enum logic [CODE_W-1:0] {
    ENT_IF       = 3'd0,
    ENT_IF_ELSE  = 3'd1,
    ENT_WHILE    = 3'd2,
    ENT_DO_WHILE = 3'd3,
    ENT_FOR      = 3'd4,
    ENT_CALL     = 3'd5,
    ENT_BLOCK    = 3'd6
  } flow_kind_t;

  typedef enum logic [CODE_W-1:0] {
    ST_OK       = 3'd0,
    ST_BAD_NODE = 3'd1,
    ST_NO_CALL  = 3'd2,
    ST_NO_LOOP  = 3'd3,
    ST_EMPTY    = 3'd4,
    ST_OVERFLOW = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic [CODE_W-1:0]   status;
    logic [CODE_W-1:0]   flow_kind;
    logic [FIELD_HW-1:0] found_node;
    logic [FIELD_HW-1:0] found_next;
    logic [DEPTH_W-1:0]  depth;
  } rsp_t;

  // entry kind for a push; only meaningful when node_kind is a legal code
  function automatic logic [CODE_W-1:0] classify(input logic [CODE_W-1:0] nk,
                                                 input logic has_else);
    logic [CODE_W-1:0] fk;
    case (nk)
      NK_IF:       fk = has_else ? ENT_IF_ELSE : ENT_IF;
      NK_WHILE:    fk = ENT_WHILE;
      NK_DO_WHILE: fk = ENT_DO_WHILE;
      NK_FOR:      fk = ENT_FOR;
      NK_CALL:     fk = ENT_CALL;
      default:     fk = ENT_BLOCK;
    endcase
    return fk;
  endfunction

endpackage

`default_nettype wire

// ===== src/cfus_ifs.sv =====
// cfus_ifs: request and response channel interfaces (valid/ready beats)
// depends on cfus_pkg for the field widths
`default_nettype none

interface cfus_req_if;
  import cfus_pkg::*;
  logic                valid;
  logic                ready;
  logic [CODE_W-1:0]   kind;
  logic [CODE_W-1:0]   node_kind;
  logic                has_else;
  logic [FIELD_HW-1:0] node_handle;
  logic [FIELD_HW-1:0] next_handle;

  modport source (output valid, kind, node_kind, has_else, node_handle, next_handle,
                  input ready);
  modport sink   (input valid, kind, node_kind, has_else, node_handle, next_handle,
                  output ready);
endinterface

interface cfus_rsp_if;
  import cfus_pkg::*;
  logic                valid;
  logic                ready;
  logic [CODE_W-1:0]   status;
  logic [CODE_W-1:0]   flow_kind;
  logic [FIELD_HW-1:0] found_node;
  logic [FIELD_HW-1:0] found_next;
  logic [DEPTH_W-1:0]  depth;

  modport source (output valid, status, flow_kind, found_node, found_next, depth,
                  input ready);
  modport sink   (input valid, status, flow_kind, found_node, found_next, depth,
                  output ready);
endinterface

`default_nettype wire

// ===== src/control_flow_unwind_stack.sv =====
// control_flow_unwind_stack: top level, sequencer, entry RAM and result register
// depends on cfus_pkg, cfus_ifs, cfus_ram and cfus_ctrl
//
// usage: one request beat on req (push, unwind to call, find loop, unwind to
// loop, peek, pop top) gives exactly one result beat on rsp with a status,
// the returned entry and the stack depth after the request. requests are
// taken one at a time; req.ready is high only while the sequencer is idle.
// a push, an error found at entry and an unknown request go from idle
// straight to the done state; peek and pop pass through the scan state to
// read the top entry; a scan examines entries from the top down, at most
// STACK_DEPTH of them. the next request can be taken at the first edge at
// which the result beat can be taken; the scan reads one RAM entry per cycle
// through the registered read port.
// a result waits in the output register while rsp.ready is low; the next
// request can be taken meanwhile, but its result is held in the sequencer
// until the register frees up.
// reset (rst, synchronous) empties the stack and drops any pending result;
// the RAM contents are not cleared and are never read before being written.
`default_nettype none

module control_flow_unwind_stack #(
  parameter int STACK_DEPTH = cfus_pkg::DEF_STACK_DEPTH,
  parameter int HANDLE_BITS = cfus_pkg::DEF_HANDLE_BITS
) (
  input wire logic   clk,
  input wire logic   rst,
  cfus_req_if.sink   req,
  cfus_rsp_if.source rsp
);
  import cfus_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int EW = CODE_W + 2 * HANDLE_BITS;

  logic          out_free;
  logic          done;
  rsp_t          res;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [EW-1:0] ram_rdata;

  logic          rsp_valid;
  rsp_t          rsp_data;

  cfus_ctrl #(
    .STACK_DEPTH (STACK_DEPTH),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .out_free  (out_free),
    .done      (done),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  cfus_ram #(
    .WIDTH (EW),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_free = !rsp_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (done) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      rsp_data <= res;
    end
  end

  assign rsp.valid      = rsp_valid;
  assign rsp.status     = rsp_data.status;
  assign rsp.flow_kind  = rsp_data.flow_kind;
  assign rsp.found_node = rsp_data.found_node;
  assign rsp.found_next = rsp_data.found_next;
  assign rsp.depth      = rsp_data.depth;

endmodule

`default_nettype wire

// ===== src/cfus_ram.sv =====
// cfus_ram: generic single-write, single-read RAM with registered read data
// no dependencies
`default_nettype none

module cfus_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/cfus_ctrl.sv =====
// cfus_ctrl: request sequencer with the shared scan/compare unit
// depends on cfus_pkg and cfus_req_if; drives the entry RAM and the result
`default_nettype none

module cfus_ctrl #(
  parameter int STACK_DEPTH = cfus_pkg::DEF_STACK_DEPTH,
  parameter int HANDLE_BITS = cfus_pkg::DEF_HANDLE_BITS
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  cfus_req_if.sink                              req,
  input  wire logic                             out_free,
  output logic                                  done,
  output cfus_pkg::rsp_t                        res,
  output logic                                  ram_we,
  output logic [$clog2(STACK_DEPTH)-1:0]        ram_waddr,
  output logic [cfus_pkg::CODE_W+2*HANDLE_BITS-1:0] ram_wdata,
  output logic [$clog2(STACK_DEPTH)-1:0]        ram_raddr,
  input  wire logic [cfus_pkg::CODE_W+2*HANDLE_BITS-1:0] ram_rdata
);
  import cfus_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int HB = HANDLE_BITS;

  ctrl_state_t       state, state_next;
  logic [CW-1:0]     count, count_next;
  logic [AW-1:0]     ptr, ptr_next;
  logic [CODE_W-1:0] op, op_next;
  rsp_t              res_next;

  logic              accept;
  logic [CW-1:0]     count_m1;
  logic              start_scan;

  // fields of the entry read back from the RAM
  logic [CODE_W-1:0] e_kind;
  logic [HB-1:0]     e_node;
  logic [HB-1:0]     e_next;
  logic              scan_match;
  logic              scan_fail;

  // pushed handles, kept at HB bits
  logic [HB-1:0]     in_node;
  logic [HB-1:0]     in_next;
  logic [HB+FIELD_HW-1:0] in_node_w, in_next_w;

  logic [FIELD_HW+HB-1:0] out_node_w, out_next_w, push_node_w, push_next_w;
  logic [CW+DEPTH_W-1:0]  depth_w;
  logic [AW+CW-1:0]       ptr_w;
  logic [CODE_W-1:0]      push_fk;

  assign accept   = req.valid && req.ready;
  assign count_m1 = count - 1'b1;

  assign in_node_w = {{HB{1'b0}}, req.node_handle};
  assign in_next_w = {{HB{1'b0}}, req.next_handle};
  assign in_node   = in_node_w[HB-1:0];
  assign in_next   = in_next_w[HB-1:0];
  assign push_fk   = classify(req.node_kind, req.has_else);

  assign e_kind = ram_rdata[CODE_W+2*HB-1 -: CODE_W];
  assign e_node = ram_rdata[2*HB-1 -: HB];
  assign e_next = ram_rdata[HB-1:0];

  assign out_node_w  = {{FIELD_HW{1'b0}}, e_node};
  assign out_next_w  = {{FIELD_HW{1'b0}}, e_next};
  assign push_node_w = {{FIELD_HW{1'b0}}, in_node};
  assign push_next_w = {{FIELD_HW{1'b0}}, in_next};
  assign depth_w     = {{DEPTH_W{1'b0}}, count_next};
  assign ptr_w       = {{CW{1'b0}}, ptr};

  assign start_scan = (req.kind != REQ_PUSH) && (req.kind <= REQ_POP) && (count != '0);

  // shared compare unit: classifies the entry at ptr for the current request
  always_comb begin
    scan_match = 1'b0;
    scan_fail  = 1'b0;
    case (op)
      REQ_UNWIND_CALL: begin
        scan_match = (e_kind == ENT_CALL);
        scan_fail  = !scan_match && (ptr == '0);
      end
      REQ_FIND_LOOP, REQ_UNWIND_LOOP: begin
        scan_match = (e_kind == ENT_WHILE) || (e_kind == ENT_DO_WHILE) ||
                     (e_kind == ENT_FOR);
        // anything that is neither a loop nor passable, or the bottom entry, stops the search
        scan_fail  = !scan_match &&
                     (((e_kind != ENT_IF) && (e_kind != ENT_IF_ELSE) &&
                       (e_kind != ENT_BLOCK)) || (ptr == '0));
      end
      default: begin
        scan_match = 1'b1;
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = start_scan ? S_SCAN : S_DONE;
        end
      end
      S_SCAN: begin
        if (scan_match || scan_fail) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    req.ready  = 1'b0;
    done       = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = count[AW-1:0];
    ram_wdata  = {push_fk, in_node, in_next};
    ram_raddr  = ptr;
    count_next = count;
    ptr_next   = ptr;
    op_next    = op;
    res_next   = res;

    unique case (state)
      S_IDLE: begin
        req.ready = 1'b1;
        ram_raddr = count_m1[AW-1:0];
        if (accept) begin
          op_next  = req.kind;
          ptr_next = count_m1[AW-1:0];
          res_next = '0;
          if (req.kind == REQ_PUSH) begin
            if (req.node_kind > NK_BLOCK) begin
              res_next.status = ST_BAD_NODE;
            end else if (count == CW'(STACK_DEPTH)) begin
              res_next.status = ST_OVERFLOW;
            end else begin
              ram_we              = 1'b1;
              count_next          = count + 1'b1;
              res_next.flow_kind  = push_fk;
              res_next.found_node = push_node_w[FIELD_HW-1:0];
              res_next.found_next = push_next_w[FIELD_HW-1:0];
            end
          end else if (req.kind <= REQ_POP && count == '0) begin
            res_next.status = ST_EMPTY;
          end
          res_next.depth = depth_w[DEPTH_W-1:0];
        end
      end
      S_SCAN: begin
        // read one entry below while this one is checked
        ram_raddr = ptr - 1'b1;
        ptr_next  = ptr - 1'b1;
        res_next  = '0;
        if (scan_match) begin
          if (op == REQ_UNWIND_CALL || op == REQ_UNWIND_LOOP || op == REQ_POP) begin
            count_next = ptr_w[CW-1:0];
          end
          res_next.status     = ST_OK;
          res_next.flow_kind  = e_kind;
          res_next.found_node = out_node_w[FIELD_HW-1:0];
          res_next.found_next = out_next_w[FIELD_HW-1:0];
        end else if (scan_fail) begin
          res_next.status = (op == REQ_UNWIND_CALL) ? ST_NO_CALL : ST_NO_LOOP;
        end
        res_next.depth = depth_w[DEPTH_W-1:0];
      end
      S_DONE: begin
        done = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    ptr <= ptr_next;
    op  <= op_next;
    res <= res_next;
  end

endmodule

`default_nettype wire

// ===== dv/cfus_checker.sv =====
// cfus_checker: shadow stack predictor and result comparator for the control-flow stack
// depends on cfus_pkg and cfus_ifs; watches both channels and never drives them
module cfus_checker #(
  parameter int STACK_DEPTH = cfus_pkg::DEF_STACK_DEPTH
) (
  input  logic clk,
  input  logic rst,
  cfus_req_if  req,
  cfus_rsp_if  rsp,
  output int   fail_count,
  output int   outstanding,
  output int   stack_level
);
  timeunit 1ns;
  timeprecision 1ps;
  import cfus_pkg::*;

  flow_kind_t          shadow_kind[STACK_DEPTH];
  logic [FIELD_HW-1:0] shadow_node[STACK_DEPTH];
  logic [FIELD_HW-1:0] shadow_next[STACK_DEPTH];
  int                  level;
  rsp_t                rsp_backlog[$];
  int                  fails;
  int                  rsp_seen;

  assign fail_count = fails;

  // slot of the nearest loop reachable past if, if-else and block entries, or -1
  function automatic int nearest_loop();
    int i;
    for (i = level - 1; i >= 0; i--) begin
      case (shadow_kind[i])
        ENT_WHILE, ENT_DO_WHILE, ENT_FOR: return i;
        ENT_CALL: return -1;
        default: ;
      endcase
    end
    return -1;
  endfunction

  function automatic rsp_t stack_outcome(input logic [CODE_W-1:0] op,
                                         input logic [CODE_W-1:0] nk,
                                         input logic he,
                                         input logic [FIELD_HW-1:0] nh,
                                         input logic [FIELD_HW-1:0] nx);
    rsp_t       r;
    int         hit;
    int         i;
    bit         legal;
    flow_kind_t fk;
    r      = '0;
    hit    = -1;
    legal  = 1'b1;
    fk     = ENT_BLOCK;
    r.status = ST_OK;
    if (op == REQ_PUSH) begin
      case (nk)
        NK_IF:       fk = he ? ENT_IF_ELSE : ENT_IF;
        NK_WHILE:    fk = ENT_WHILE;
        NK_DO_WHILE: fk = ENT_DO_WHILE;
        NK_FOR:      fk = ENT_FOR;
        NK_CALL:     fk = ENT_CALL;
        NK_BLOCK:    fk = ENT_BLOCK;
        default:     legal = 1'b0;
      endcase
      if (!legal) begin
        r.status = ST_BAD_NODE;
      end else if (level >= STACK_DEPTH) begin
        r.status = ST_OVERFLOW;
      end else begin
        shadow_kind[level] = fk;
        shadow_node[level] = nh;
        shadow_next[level] = nx;
        hit = level;
        level++;
      end
    end else if (op > REQ_POP) begin
      // unknown request: nothing changes
    end else if (level == 0) begin
      r.status = ST_EMPTY;
    end else begin
      case (op)
        REQ_UNWIND_CALL: begin
          i = level;
          while (i > 0 && shadow_kind[i-1] != ENT_CALL) i--;
          if (i == 0) begin
            r.status = ST_NO_CALL;
          end else begin
            hit   = i - 1;
            level = hit;
          end
        end
        REQ_FIND_LOOP: begin
          hit = nearest_loop();
          if (hit < 0) r.status = ST_NO_LOOP;
        end
        REQ_UNWIND_LOOP: begin
          hit = nearest_loop();
          if (hit < 0) r.status = ST_NO_LOOP;
          else level = hit;
        end
        REQ_PEEK: begin
          hit = level - 1;
        end
        default: begin
          hit   = level - 1;
          level = hit;
        end
      endcase
    end
    if (hit >= 0) begin
      r.flow_kind  = shadow_kind[hit];
      r.found_node = shadow_node[hit];
      r.found_next = shadow_next[hit];
    end
    r.depth = level[DEPTH_W-1:0];
    return r;
  endfunction

  task automatic flag(input string field, input logic [FIELD_HW-1:0] got,
                      input logic [FIELD_HW-1:0] want);
    $display("[%0t] result beat %0d: %s mismatch, got %h want %h",
             $realtime, rsp_seen, field, got, want);
    fails++;
  endtask

  always @(posedge clk) begin
    rsp_t got;
    rsp_t want;
    if (rst) begin
      level = 0;
      rsp_backlog.delete();
      fails = 0;
      rsp_seen = 0;
    end else begin
      // a result never leaves in the cycle its request is taken, so check first
      if (rsp.valid && rsp.ready) begin
        got = '{rsp.status, rsp.flow_kind, rsp.found_node, rsp.found_next, rsp.depth};
        if (rsp_backlog.size() == 0) begin
          $display("[%0t] result beat %0d arrived with nothing outstanding",
                   $realtime, rsp_seen);
          fails++;
        end else begin
          want = rsp_backlog.pop_front();
          if (got.status !== want.status)
            flag("status", FIELD_HW'(got.status), FIELD_HW'(want.status));
          if (got.flow_kind !== want.flow_kind)
            flag("flow_kind", FIELD_HW'(got.flow_kind), FIELD_HW'(want.flow_kind));
          if (got.found_node !== want.found_node)
            flag("found_node", got.found_node, want.found_node);
          if (got.found_next !== want.found_next)
            flag("found_next", got.found_next, want.found_next);
          if (got.depth !== want.depth)
            flag("depth", FIELD_HW'(got.depth), FIELD_HW'(want.depth));
        end
        rsp_seen++;
      end
      if (req.valid && req.ready) begin
        rsp_backlog.push_back(stack_outcome(req.kind, req.node_kind, req.has_else,
                                            req.node_handle, req.next_handle));
      end
    end
    outstanding <= rsp_backlog.size();
    stack_level <= level;
  end

endmodule

// ===== dv/control_flow_unwind_stack_tb.sv =====
// control_flow_unwind_stack_tb: request stimulus, response back-pressure and verdict
// depends on cfus_pkg, cfus_ifs, the block itself and cfus_checker
module control_flow_unwind_stack_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cfus_pkg::*;

  localparam int TOTAL_ITEMS = 1100;
  localparam int DEEP_EVERY  = 350;
  localparam int IDLE_LIMIT  = 5000;
  localparam int TAIL_CYCLES = 100;

  // request and node codes outside the legal enum ranges
  localparam logic [CODE_W-1:0] REQ_UNKNOWN_LO = 3'd6;
  localparam logic [CODE_W-1:0] REQ_UNKNOWN_HI = 3'd7;
  localparam logic [CODE_W-1:0] NK_OTHER       = 3'd6;
  localparam logic [CODE_W-1:0] NK_UNDEF       = 3'd7;

  typedef struct packed {
    logic [CODE_W-1:0]   kind;
    logic [CODE_W-1:0]   node_kind;
    logic                has_else;
    logic [FIELD_HW-1:0] node_handle;
    logic [FIELD_HW-1:0] next_handle;
  } req_beat_t;

  logic clk;
  logic rst;
  int   fail_count;
  int   outstanding;
  int   stack_level;
  int   beats_sent;
  int   idle_run;
  bit   quiet;

  cfus_req_if req_ch();
  cfus_rsp_if rsp_ch();

  control_flow_unwind_stack dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  cfus_checker #(.STACK_DEPTH(DEF_STACK_DEPTH)) checker_i (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding),
    .stack_level (stack_level)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int draw_wait();
    return quiet ? 0 : $urandom_range(0, 9);
  endfunction

  function automatic req_beat_t req_beat(input logic [CODE_W-1:0] kind,
                                         input logic [CODE_W-1:0] nk,
                                         input logic he,
                                         input logic [FIELD_HW-1:0] nh,
                                         input logic [FIELD_HW-1:0] nx);
    return '{kind, nk, he, nh, nx};
  endfunction

  function automatic req_beat_t random_beat(input int lvl);
    req_beat_t b;
    int        r;
    r = $urandom_range(0, 99);
    b = req_beat(REQ_PUSH, CODE_W'($urandom_range(NK_IF, NK_BLOCK)),
                 1'($urandom_range(0, 1)), $urandom, $urandom);
    if ((lvl == 0 && r < 75) || r < 42) b.kind = REQ_PUSH;
    else if (r < 45) b.node_kind = CODE_W'($urandom_range(NK_OTHER, NK_UNDEF));
    else if (r < 48) b.kind = CODE_W'($urandom_range(REQ_UNKNOWN_LO, REQ_UNKNOWN_HI));
    else if (r < 56) b.kind = REQ_UNWIND_CALL;
    else if (r < 70) b.kind = REQ_FIND_LOOP;
    else if (r < 80) b.kind = REQ_UNWIND_LOOP;
    else if (r < 89) b.kind = REQ_PEEK;
    else b.kind = REQ_POP;
    return b;
  endfunction

  // waits out the sender gap; ends on a falling edge ready to drive
  task automatic next_slot();
    int gap;
    gap = draw_wait();
    @(negedge clk);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic offer(input req_beat_t b);
    req_ch.valid       <= 1'b1;
    req_ch.kind        <= b.kind;
    req_ch.node_kind   <= b.node_kind;
    req_ch.has_else    <= b.has_else;
    req_ch.node_handle <= b.node_handle;
    req_ch.next_handle <= b.next_handle;
    do @(posedge clk); while (!req_ch.ready);
    beats_sent++;
  endtask

  task automatic send(input req_beat_t b);
    next_slot();
    offer(b);
  endtask

  task automatic pause_for_results();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    wait (outstanding == 0);
  endtask

  // fill to the top over a loop or call pushed first, overflow, then search and unwind down the stack
  task automatic deep_phase(input bit call_at_bottom);
    int        room;
    int        k;
    req_beat_t b;
    pause_for_results();
    room = DEF_STACK_DEPTH - stack_level;
    for (k = 0; k < room; k++) begin
      next_slot();
      b = req_beat(REQ_PUSH, $urandom_range(0, 1) ? NK_IF : NK_BLOCK,
                   1'($urandom_range(0, 1)), $urandom, $urandom);
      if (k == 0) b.node_kind = call_at_bottom ? NK_CALL
                                               : CODE_W'($urandom_range(NK_WHILE, NK_FOR));
      offer(b);
    end
    repeat (2) send(req_beat(REQ_PUSH, CODE_W'($urandom_range(NK_IF, NK_BLOCK)),
                             1'($urandom_range(0, 1)), $urandom, $urandom));
    send(req_beat(REQ_FIND_LOOP, NK_IF, 1'b0, '0, '0));
    send(req_beat(REQ_UNWIND_LOOP, NK_IF, 1'b0, '0, '0));
    send(req_beat(REQ_UNWIND_CALL, NK_IF, 1'b0, '0, '0));
    send(req_beat(REQ_PEEK, NK_IF, 1'b0, '0, '0));
    pause_for_results();
  endtask

  // response side back-pressure
  initial begin
    int stall;
    rsp_ch.ready = 1'b0;
    forever begin
      stall = draw_wait();
      repeat (stall) begin
        @(negedge clk);
        rsp_ch.ready <= 1'b0;
      end
      @(negedge clk);
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_run <= 0;
    end else if (idle_run >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  initial begin
    int next_deep;
    int phase;
    rst                = 1'b1;
    quiet              = 1'b0;
    beats_sent         = 0;
    req_ch.valid       = 1'b0;
    req_ch.kind        = REQ_PUSH;
    req_ch.node_kind   = NK_IF;
    req_ch.has_else    = 1'b0;
    req_ch.node_handle = '0;
    req_ch.next_handle = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty stack and codes outside the legal ranges
    send(req_beat(REQ_PEEK, NK_IF, 1'b0, '0, '0));
    send(req_beat(REQ_POP, NK_IF, 1'b0, '0, '0));
    send(req_beat(REQ_UNWIND_CALL, NK_IF, 1'b0, '0, '0));
    send(req_beat(REQ_FIND_LOOP, NK_IF, 1'b0, '0, '0));
    send(req_beat(REQ_UNWIND_LOOP, NK_IF, 1'b0, '0, '0));
    send(req_beat(REQ_UNKNOWN_LO, NK_IF, 1'b0, '0, '0));
    send(req_beat(REQ_UNKNOWN_HI, NK_UNDEF, 1'b1, '1, '1));
    send(req_beat(REQ_PUSH, NK_OTHER, 1'b0, '1, '0));
    send(req_beat(REQ_PUSH, NK_UNDEF, 1'b1, '0, '1));
    // one of every entry kind, handle extremes
    send(req_beat(REQ_PUSH, NK_IF, 1'b0, '0, '0));
    send(req_beat(REQ_PUSH, NK_IF, 1'b1, '1, '1));
    send(req_beat(REQ_PUSH, NK_WHILE, 1'b1, 32'h0000_FFFF, 32'hFFFF_0000));
    send(req_beat(REQ_PUSH, NK_DO_WHILE, 1'b0, 32'hAAAA_AAAA, 32'h5555_5555));
    send(req_beat(REQ_PUSH, NK_FOR, 1'b1, 32'h5555_5555, 32'hAAAA_AAAA));
    send(req_beat(REQ_PUSH, NK_CALL, 1'b0, 32'h0000_0001, 32'h8000_0000));
    send(req_beat(REQ_PUSH, NK_BLOCK, 1'b1, 32'h8000_0000, 32'h0000_0001));
    // loop search blocked by a call, then unwinds past the call and down to the while loop
    send(req_beat(REQ_FIND_LOOP, NK_IF, 1'b0, '0, '0));
    send(req_beat(REQ_UNWIND_LOOP, NK_IF, 1'b0, '0, '0));
    send(req_beat(REQ_UNWIND_CALL, NK_IF, 1'b0, '0, '0));
    send(req_beat(REQ_FIND_LOOP, NK_IF, 1'b0, '0, '0));
    send(req_beat(REQ_PEEK, NK_IF, 1'b0, '0, '0));
    send(req_beat(REQ_POP, NK_IF, 1'b0, '0, '0));
    send(req_beat(REQ_UNWIND_LOOP, NK_IF, 1'b0, '0, '0));
    send(req_beat(REQ_UNWIND_CALL, NK_IF, 1'b0, '0, '0));
    send(req_beat(REQ_FIND_LOOP, NK_IF, 1'b0, '0, '0));

    next_deep = beats_sent + DEEP_EVERY / 2;
    phase     = 0;
    while (beats_sent < TOTAL_ITEMS) begin
      if (beats_sent >= next_deep) begin
        deep_phase(phase[0]);
        phase++;
        next_deep += DEEP_EVERY;
      end
      if ($urandom_range(0, 63) == 0) quiet = !quiet;
      next_slot();
      offer(random_beat(stack_level));
    end

    pause_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
